// ===== sv/dhm_pkg.sv =====
// Shared constants and types of the Diffie-Hellman modular exponentiation block.
package dhm_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int EXP_WIDTH   = 16;

    localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = VALUE_WIDTH'(9999);

    // Counter widths for the multiplier steps and the exponent bits.
    localparam int MUL_CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int EXP_CNT_W = $clog2(EXP_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [EXP_WIDTH-1:0]   expo_t;

    // Command to the shared modular multiplier.
    typedef struct packed {
        logic   start;
        value_t mcand;
        value_t mplier;
    } mm_cmd_t;

    // Status returned by the shared modular multiplier.
    typedef struct packed {
        logic   done;
        value_t product;
    } mm_sts_t;

endpackage

// ===== sv/dhm_in_if.sv =====
// Input channel carrying the bases and the private exponent.
interface dhm_in_if;
    import dhm_pkg::*;

    logic   valid;
    logic   ready;
    value_t generator;
    value_t peer_public;
    expo_t  private_exponent;

    modport source (output valid, output generator, output peer_public,
                    output private_exponent, input ready);
    modport sink (input valid, input generator, input peer_public,
                  input private_exponent, output ready);
endinterface

// ===== sv/dhm_out_if.sv =====
// Output channel carrying the own public value and the shared key.
interface dhm_out_if;
    import dhm_pkg::*;

    logic   valid;
    logic   ready;
    value_t own_public;
    value_t shared_key;

    modport source (output valid, output own_public, output shared_key, input ready);
    modport sink (input valid, input own_public, input shared_key, output ready);
endinterface

// ===== sv/dh_modexp_pair.sv =====
// Top level of the Diffie-Hellman modular exponentiation block.
//
// The block computes one key exchange step per input beat. An input beat on
// the operands channel carries a generator, the peer's public value and a
// private exponent. One output beat on the results channel returns
// generator^exponent and peer_public^exponent, both reduced by the modulus.
// The user must write the modulus through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
//
// Both exponentiations run square-and-multiply, LSB first, on one shared
// bit-serial modular multiplier. An item takes two base reductions plus, for
// each of the EXP_WIDTH exponent bits, a dispatch state, two squarings and
// two multiplies per set bit. A zero exponent or a modulus below two skips
// the multiplier and goes straight to the finish state. The operands channel
// is ready only while the sequencer is idle, one item at a time.
//
// Results sit in an output register, so a new item is accepted while the
// previous result still waits; a finished item holds until that register is
// free. Reset clears the sequencer and output valid and loads the modulus
// with its default of 9999.
module dh_modexp_pair (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  dhm_pkg::value_t cfg_wdata,
    dhm_in_if.sink          operands,
    dhm_out_if.source       results
);
    import dhm_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RED_G  = 4'd1;
    localparam logic [3:0] S_RED_A  = 4'd2;
    localparam logic [3:0] S_BIT    = 4'd3;
    localparam logic [3:0] S_ACC_G  = 4'd4;
    localparam logic [3:0] S_SQ_G   = 4'd5;
    localparam logic [3:0] S_ACC_A  = 4'd6;
    localparam logic [3:0] S_SQ_A   = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [EXP_CNT_W-1:0] bit_reg, bit_next;
    logic                 start_reg, start_next;
    logic                 out_valid_reg, out_valid_next;
    value_t               modulus_reg;

    value_t mcand_reg, mcand_next;
    value_t mplier_reg, mplier_next;
    value_t sq_g_reg, sq_g_next;
    value_t sq_a_reg, sq_a_next;
    value_t acc_g_reg, acc_g_next;
    value_t acc_a_reg, acc_a_next;
    expo_t  exp_reg, exp_next;
    value_t own_reg, own_next;
    value_t key_reg, key_next;

    mm_cmd_t mm_cmd;
    mm_sts_t mm_sts;

    logic in_fire;
    logic out_free;

    assign in_fire  = operands.valid && operands.ready;
    assign out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    assign mm_cmd.start  = start_reg;
    assign mm_cmd.mcand  = mcand_reg;
    assign mm_cmd.mplier = mplier_reg;

    dhm_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mm_cmd),
        .modulus (modulus_reg),
        .sts     (mm_sts)
    );

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        sq_g_next      = sq_g_reg;
        sq_a_next      = sq_a_reg;
        acc_g_next     = acc_g_reg;
        acc_a_next     = acc_a_reg;
        exp_next       = exp_reg;
        own_next       = own_reg;
        key_next       = key_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sq_g_next = operands.generator;
                    sq_a_next = operands.peer_public;
                    exp_next  = operands.private_exponent;
                    bit_next  = EXP_CNT_W'(EXP_WIDTH - 1);
                    if (operands.private_exponent == '0)
                    begin
                        // Any base to the power zero gives one.
                        acc_g_next = VALUE_WIDTH'(1);
                        acc_a_next = VALUE_WIDTH'(1);
                        state_next = S_FINISH;
                    end
                    else if (modulus_reg < VALUE_WIDTH'(2))
                    begin
                        // Degenerate modulus: every reduction gives zero.
                        acc_g_next = '0;
                        acc_a_next = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Reduce the generator by multiplying it by one.
                        mcand_next  = VALUE_WIDTH'(1);
                        mplier_next = operands.generator;
                        start_next  = 1'b1;
                        state_next  = S_RED_G;
                    end
                end
            end
            S_RED_G:
            begin
                if (mm_sts.done)
                begin
                    sq_g_next   = mm_sts.product;
                    mcand_next  = VALUE_WIDTH'(1);
                    mplier_next = sq_a_reg;
                    start_next  = 1'b1;
                    state_next  = S_RED_A;
                end
            end
            S_RED_A:
            begin
                if (mm_sts.done)
                begin
                    sq_a_next  = mm_sts.product;
                    acc_g_next = VALUE_WIDTH'(1);
                    acc_a_next = VALUE_WIDTH'(1);
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                start_next = 1'b1;
                if (exp_reg[0])
                begin
                    mcand_next  = acc_g_reg;
                    mplier_next = sq_g_reg;
                    state_next  = S_ACC_G;
                end
                else
                begin
                    mcand_next  = sq_g_reg;
                    mplier_next = sq_g_reg;
                    state_next  = S_SQ_G;
                end
            end
            S_ACC_G:
            begin
                if (mm_sts.done)
                begin
                    acc_g_next  = mm_sts.product;
                    mcand_next  = sq_g_reg;
                    mplier_next = sq_g_reg;
                    start_next  = 1'b1;
                    state_next  = S_SQ_G;
                end
            end
            S_SQ_G:
            begin
                if (mm_sts.done)
                begin
                    sq_g_next  = mm_sts.product;
                    start_next = 1'b1;
                    if (exp_reg[0])
                    begin
                        mcand_next  = acc_a_reg;
                        mplier_next = sq_a_reg;
                        state_next  = S_ACC_A;
                    end
                    else
                    begin
                        mcand_next  = sq_a_reg;
                        mplier_next = sq_a_reg;
                        state_next  = S_SQ_A;
                    end
                end
            end
            S_ACC_A:
            begin
                if (mm_sts.done)
                begin
                    acc_a_next  = mm_sts.product;
                    mcand_next  = sq_a_reg;
                    mplier_next = sq_a_reg;
                    start_next  = 1'b1;
                    state_next  = S_SQ_A;
                end
            end
            S_SQ_A:
            begin
                if (mm_sts.done)
                begin
                    sq_a_next = mm_sts.product;
                    exp_next  = {1'b0, exp_reg[EXP_WIDTH-1:1]};
                    bit_next  = bit_reg - EXP_CNT_W'(1);
                    if (bit_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
            end
            S_FINISH:
            begin
                // Hand the pair to the output register once it is free.
                if (out_free)
                begin
                    own_next       = acc_g_reg;
                    key_next       = acc_a_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_reg       <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        sq_g_reg   <= sq_g_next;
        sq_a_reg   <= sq_a_next;
        acc_g_reg  <= acc_g_next;
        acc_a_reg  <= acc_a_next;
        exp_reg    <= exp_next;
        own_reg    <= own_next;
        key_reg    <= key_next;
    end

    assign operands.ready     = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.own_public = own_reg;
    assign results.shared_key = key_reg;

endmodule

// ===== sv/dhm_mulmod.sv =====
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module dhm_mulmod (
    input  logic             clk,
    input  logic             rst_n,
    input  dhm_pkg::mm_cmd_t cmd,
    input  dhm_pkg::value_t  modulus,
    output dhm_pkg::mm_sts_t sts
);
    import dhm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    value_t               r_reg;
    value_t               mcand_reg;
    value_t               mplier_reg;

    logic [VALUE_WIDTH:0] m_ext;
    logic [VALUE_WIDTH:0] dbl;
    logic [VALUE_WIDTH:0] red1;
    logic [VALUE_WIDTH:0] addend;
    logic [VALUE_WIDTH:0] sum;
    logic [VALUE_WIDTH:0] red2;
    value_t               r_next;

    // The partial result stays below the modulus, so each step needs at most
    // one subtraction after the doubling and one after the add.
    always_comb
    begin
        m_ext  = {1'b0, modulus};
        dbl    = {r_reg, 1'b0};
        red1   = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        addend = mplier_reg[VALUE_WIDTH-1] ? {1'b0, mcand_reg} : '0;
        sum    = red1 + addend;
        red2   = (sum >= m_ext) ? (sum - m_ext) : sum;
        r_next = red2[VALUE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_CNT_W'(VALUE_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r_reg      <= '0;
            mcand_reg  <= cmd.mcand;
            mplier_reg <= cmd.mplier;
        end
        else if (busy_reg)
        begin
            r_reg      <= r_next;
            mplier_reg <= {mplier_reg[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign sts.done    = done_reg;
    assign sts.product = r_reg;

endmodule
